[rtl/bfcc_pkg.sv]
// shared types and constants of the box face contact clipper
package bfcc_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 104;

    localparam int T_BITS       = 16;
    localparam int MAX_VERTICES = 8;
    localparam int NUM_CELLS    = 2 * MAX_VERTICES;
    localparam int CELL_IDX_W   = $clog2(NUM_CELLS);
    localparam int NUM_SLOTS    = 11;
    localparam int SLOT_W       = 4;
    localparam int NUM_AXES     = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_REF_HALF  = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_INC_CTR   = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_INC_AX0   = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_INC_AX1   = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_INC_AX2   = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_INC_HALF  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_NORMAL    = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_FACE_CTR  = 4'd10;

    typedef struct packed {
        logic                  pop;
        logic                  push;
        logic [CELL_IDX_W-1:0] wpos;
    } t_chain_ctl;

endpackage

[rtl/bfcc_ram.sv]
// generic single write port ram with registered read
module bfcc_ram #(
    parameter int W     = 96,
    parameter int DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bfcc_cell.sv]
// one vertex cell of the polygon queue chain
module bfcc_cell #(
    parameter int W   = 96,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  bfcc_pkg::t_chain_ctl i_ctl,
    input  logic [W-1:0]         i_next,
    input  logic [W-1:0]         i_push_data,
    output logic [W-1:0]         o_data
);

    logic [W-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && i_ctl.wpos == (bfcc_pkg::CELL_IDX_W)'(IDX)) begin
            r_v <= i_push_data;
        end else if (i_ctl.pop) begin
            r_v <= i_next;
        end
    end

    assign o_data = r_v;

endmodule

[rtl/bfcc_div.sv]
// iterative divider for the clip parameter, one quotient bit per cycle
module bfcc_div #(
    parameter int W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [W-1:0]                i_num,
    input  logic [W:0]                  i_den,
    output logic                        o_done,
    output logic [bfcc_pkg::T_BITS-1:0] o_t
);

    localparam int CNT_W = $clog2(bfcc_pkg::T_BITS + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [W+1:0]                r_rem;
    logic [W+1:0]                r_den;
    logic [bfcc_pkg::T_BITS-1:0] r_q;
    logic                        r_top;
    logic [W+1:0]                n_rem2;

    assign n_rem2 = {r_rem[W:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= (W+2)'(i_den);
                r_q   <= '0;
                if (i_den == '0) begin
                    r_top  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_top  <= ((W+1)'(i_num) >= i_den);
                    r_rem  <= ((W+1)'(i_num) >= i_den) ?
                              (W+2)'(i_num) - (W+2)'(i_den) : (W+2)'(i_num);
                    r_cnt  <= CNT_W'(bfcc_pkg::T_BITS);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (n_rem2 >= r_den) begin
                    r_rem <= n_rem2 - r_den;
                    r_q   <= {r_q[bfcc_pkg::T_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem2;
                    r_q   <= {r_q[bfcc_pkg::T_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_t    = r_top ? '1 : r_q;

endmodule

[rtl/box_face_contact_clipper_core.sv]
// box face contact clipper: top level with sequencer, shared multiplier and vertex chain
//
// slave stream: one transaction per item. tuser selects load (0) or start (1).
// a load writes one vector slot. a start computes the
// incident face and clips it against four side planes of the reference face.
// master stream: one transaction per surviving vertex, tlast on the final
// one; tuser flags an empty polygon, sent as one all-zero transaction.
// a start runs a setup of loads and products, then clips each edge of each
// pass, with a division when the edge crosses the plane; the divider takes
// 16 steps, and the setup and plane products run on the shared multiplier.
// the vertex polygon lives in a chain of 16 cells used as a queue.
// tready on the slave side is high only while no start is in work.
// the result register is freed when the receiver takes it; while the
// receiver stalls the block holds the result and waits.
// reset clears the loaded slot valid bits (slots read as zero), the queue
// fill count and the output valid.
module box_face_contact_clipper_core #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // slot, vec_x, vec_y, vec_z, reference_axis
    input  logic [bfcc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // op
    input  logic [0:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // point_x, point_y, point_z, vertex_number
    output logic [bfcc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    // is_empty
    output logic [0:0]                          o_m_axis_tuser
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int WW = ((CW > 32) ? CW : 32) + 2;
    localparam int VW = 3 * CW;
    localparam int NC = bfcc_pkg::NUM_CELLS;
    localparam int TB = bfcc_pkg::T_BITS;

    localparam logic signed [WW-1:0] LMAX = ((WW'(1)) <<< (CW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] LMIN = -LMAX - WW'(1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LD     = 5'd1;
    localparam logic [4:0] S_DOT    = 5'd2;
    localparam logic [4:0] S_DOTR   = 5'd3;
    localparam logic [4:0] S_PICK   = 5'd4;
    localparam logic [4:0] S_BC     = 5'd5;
    localparam logic [4:0] S_U      = 5'd6;
    localparam logic [4:0] S_W      = 5'd7;
    localparam logic [4:0] S_CORN   = 5'd8;
    localparam logic [4:0] S_PSET   = 5'd9;
    localparam logic [4:0] S_OFF    = 5'd10;
    localparam logic [4:0] S_PBEG   = 5'd11;
    localparam logic [4:0] S_DS     = 5'd12;
    localparam logic [4:0] S_EDGE   = 5'd13;
    localparam logic [4:0] S_DE     = 5'd14;
    localparam logic [4:0] S_DEC    = 5'd15;
    localparam logic [4:0] S_DIV    = 5'd16;
    localparam logic [4:0] S_INT    = 5'd17;
    localparam logic [4:0] S_INT2   = 5'd18;
    localparam logic [4:0] S_PUSHE  = 5'd19;
    localparam logic [4:0] S_NEXT   = 5'd20;
    localparam logic [4:0] S_PEND   = 5'd21;
    localparam logic [4:0] S_OSTART = 5'd22;
    localparam logic [4:0] S_OUT    = 5'd23;
    localparam logic [4:0] S_OEMPTY = 5'd24;
    localparam logic [4:0] S_MUL    = 5'd25;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [2:0][CW-1:0]   t_vec;

    function automatic t_coord sat(input logic signed [WW-1:0] x);
        if (x > LMAX) begin
            return CW'(LMAX);
        end else if (x < LMIN) begin
            return CW'(LMIN);
        end
        return CW'(x);
    endfunction

    function automatic t_coord addq(input t_coord a, input t_coord b);
        return sat(WW'(a) + WW'(b));
    endfunction

    function automatic t_coord subq(input t_coord a, input t_coord b);
        return sat(WW'(a) - WW'(b));
    endfunction

    function automatic t_coord negq(input t_coord a);
        return sat(-WW'(a));
    endfunction

    function automatic t_coord absq(input t_coord a);
        return sat(a[CW-1] ? -WW'(a) : WW'(a));
    endfunction

    function automatic t_coord qmul(input t_coord a, input t_coord b);
        logic              neg;
        logic [CW-1:0]     ua;
        logic [CW-1:0]     ub;
        logic [2*CW-1:0]   pr;
        logic [2*CW-1:0]   lim;
        neg = a[CW-1] ^ b[CW-1];
        ua  = a[CW-1] ? (~a + 1'b1) : a;
        ub  = b[CW-1] ? (~b + 1'b1) : b;
        pr  = ((2*CW)'(ua) * (2*CW)'(ub)) >> FB;
        lim = ((2*CW)'(1) << (CW - 1)) - (2*CW)'(!neg);
        if (pr > lim) begin
            pr = lim;
        end
        return neg ? CW'(-pr) : CW'(pr);
    endfunction

    // input fields
    logic                          w_in_acc;
    logic                          w_op;
    logic [bfcc_pkg::SLOT_W-1:0]   w_slot;
    logic signed [31:0]            w_vx, w_vy, w_vz;
    logic [1:0]                    w_ref;

    assign w_op  = i_s_axis_tuser[0];
    assign w_slot = i_s_axis_tdata[3:0];
    assign w_vx  = i_s_axis_tdata[35:4];
    assign w_vy  = i_s_axis_tdata[67:36];
    assign w_vz  = i_s_axis_tdata[99:68];
    assign w_ref = i_s_axis_tdata[101:100];

    logic [4:0]  r_state;
    logic [4:0]  r_ret;
    logic [bfcc_pkg::NUM_SLOTS-1:0] r_valid;
    logic        r_rdv;
    logic [1:0]  r_ref;
    logic [3:0]  r_lc;
    logic [1:0]  r_k;
    logic [1:0]  r_b;
    logic [1:0]  r_pass;
    logic [3:0]  r_n;
    logic [3:0]  r_m;
    logic [2:0]  r_i;
    logic [2:0]  r_oi;
    logic [$clog2(NC+1)-1:0] r_cnt;

    t_vec   r_nrm, r_fc, r_vn, r_hn, r_ih, r_ctr, r_bn, r_bc, r_u, r_w, r_pn;
    t_vec   r_inc [3];
    t_coord r_dot [3];
    t_coord r_vh, r_hh, r_off, r_ds, r_de;
    t_vec   r_s, r_e, r_f;
    logic [TB-1:0] r_t;
    logic [2:0][CW-1:0] r_ip;
    logic [2:0] r_dneg;

    t_vec   r_ma, r_mb, r_res;
    logic [1:0] r_mk, r_pk;
    logic   r_pv;
    t_coord r_prod;
    logic signed [WW-1:0] r_acc;

    t_coord r_ox, r_oy, r_oz;
    logic [2:0] r_onum;
    logic   r_olast, r_oempty, r_ov;

    // ram
    logic                        w_we;
    logic [bfcc_pkg::SLOT_W-1:0] w_raddr;
    logic [VW-1:0]               w_rdata;
    t_vec                        w_ld;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_we = w_in_acc && (w_op == bfcc_pkg::OP_LOAD) &&
                  (w_slot <= bfcc_pkg::SLOT_FACE_CTR);

    bfcc_ram #(.W(VW), .DEPTH(bfcc_pkg::NUM_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata ({sat(WW'(w_vz)), sat(WW'(w_vy)), sat(WW'(w_vx))}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ld = r_rdv ? w_rdata : '0;

    logic [1:0] w_vi, w_hi;
    assign w_vi = (r_ref == 2'd0) ? 2'd1 : ((r_ref == 2'd1) ? 2'd2 : 2'd0);
    assign w_hi = (r_ref == 2'd0) ? 2'd2 : ((r_ref == 2'd1) ? 2'd0 : 2'd1);

    always_comb begin
        case (r_lc)
            4'd0:    w_raddr = bfcc_pkg::SLOT_NORMAL;
            4'd1:    w_raddr = bfcc_pkg::SLOT_FACE_CTR;
            4'd2:    w_raddr = bfcc_pkg::SLOT_W'(w_vi);
            4'd3:    w_raddr = bfcc_pkg::SLOT_W'(w_hi);
            4'd4:    w_raddr = bfcc_pkg::SLOT_REF_HALF;
            4'd5:    w_raddr = bfcc_pkg::SLOT_INC_HALF;
            4'd6:    w_raddr = bfcc_pkg::SLOT_INC_CTR;
            4'd7:    w_raddr = bfcc_pkg::SLOT_INC_AX0;
            4'd8:    w_raddr = bfcc_pkg::SLOT_INC_AX1;
            4'd9:    w_raddr = bfcc_pkg::SLOT_INC_AX2;
            default: w_raddr = bfcc_pkg::SLOT_NORMAL;
        endcase
    end

    // vertex chain
    bfcc_pkg::t_chain_ctl w_ctl;
    logic          c_pop, c_push;
    logic [VW-1:0] c_pdata;
    logic [VW-1:0] w_cell [NC+1];
    t_vec          w_head;

    assign w_cell[NC] = '0;
    assign w_head     = w_cell[0];

    for (genvar g = 0; g < NC; g++) begin : g_cell
        bfcc_cell #(.W(VW), .IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_next      (w_cell[g+1]),
            .i_push_data (c_pdata),
            .o_data      (w_cell[g])
        );
    end

    assign w_ctl.pop  = c_pop;
    assign w_ctl.push = c_push;
    assign w_ctl.wpos = c_pop ? bfcc_pkg::CELL_IDX_W'(r_cnt - 1'b1)
                              : bfcc_pkg::CELL_IDX_W'(r_cnt);

    // datapath helpers
    logic   w_last_edge, w_in_s, w_in_e, w_push_ok, w_out_load;
    t_vec   w_corner, w_pt, w_pn;
    logic [1:0] w_pick;
    t_vec   w_pick_bn;
    logic [1:0] w_bv, w_bh;
    t_coord w_dk;
    logic [CW-1:0] w_ud;
    logic   w_div_start, w_div_done;
    logic [TB-1:0] w_t;
    logic [CW-1:0] w_num;
    logic signed [CW:0] w_diff;
    logic [CW:0]   w_den;

    assign w_last_edge = ((4'(r_i) + 4'd1) == r_n);
    assign w_in_s      = r_ds[CW-1] || (r_ds == '0);
    assign w_in_e      = r_de[CW-1] || (r_de == '0);
    assign w_push_ok   = (r_m < 4'(bfcc_pkg::MAX_VERTICES));
    assign w_out_load  = !r_ov || i_m_axis_tready;
    assign w_bv = (r_b == 2'd0) ? 2'd1 : ((r_b == 2'd1) ? 2'd2 : 2'd0);
    assign w_bh = (r_b == 2'd0) ? 2'd2 : ((r_b == 2'd1) ? 2'd0 : 2'd1);

    always_comb begin
        t_coord bu;
        for (int j = 0; j < 3; j++) begin
            bu = (r_k == 2'd0 || r_k == 2'd3) ?
                 addq($signed(r_bc[j]), $signed(r_u[j])) :
                 subq($signed(r_bc[j]), $signed(r_u[j]));
            w_corner[j] = (r_k <= 2'd1) ? addq(bu, $signed(r_w[j]))
                                        : subq(bu, $signed(r_w[j]));
            w_pt[j] = sat(WW'($signed(r_s[j])) + (r_dneg[j] ?
                      -$signed(WW'(r_ip[j])) : $signed(WW'(r_ip[j]))));
            case (r_pass)
                2'd0:    w_pn[j] = r_vn[j];
                2'd1:    w_pn[j] = negq($signed(r_vn[j]));
                2'd2:    w_pn[j] = r_hn[j];
                default: w_pn[j] = negq($signed(r_hn[j]));
            endcase
        end
    end

    always_comb begin
        t_coord a0, a1, a2, best;
        a0 = absq(r_dot[0]);
        a1 = absq(r_dot[1]);
        a2 = absq(r_dot[2]);
        w_pick = 2'd0;
        best   = a0;
        if (a1 > best) begin
            w_pick = 2'd1;
            best   = a1;
        end
        if (a2 > best) begin
            w_pick = 2'd2;
        end
        for (int j = 0; j < 3; j++) begin
            w_pick_bn[j] = (r_dot[w_pick] > 0) ? negq($signed(r_inc[w_pick][j]))
                                               : r_inc[w_pick][j];
        end
    end

    assign w_dk   = subq($signed(r_e[r_k]), $signed(r_s[r_k]));
    assign w_ud   = w_dk[CW-1] ? (~w_dk + 1'b1) : w_dk;
    assign w_num  = r_ds[CW-1] ? (~r_ds + 1'b1) : r_ds;
    assign w_diff = (CW+1)'(r_ds) - (CW+1)'(r_de);
    assign w_den  = w_diff[CW] ? (~w_diff + 1'b1) : w_diff;
    assign w_div_start = (r_state == S_DEC) && (w_in_s != w_in_e);

    bfcc_div #(.W(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_t     (w_t)
    );

    always_comb begin
        c_pop   = 1'b0;
        c_push  = 1'b0;
        c_pdata = w_head;
        case (r_state)
            S_CORN: begin
                c_push  = 1'b1;
                c_pdata = w_corner;
            end
            S_PBEG: begin
                c_pop = 1'b1;
            end
            S_EDGE: begin
                c_pop = !w_last_edge;
            end
            S_DEC: begin
                c_push  = w_in_s && w_in_e && w_push_ok;
                c_pdata = r_e;
            end
            S_INT2: begin
                c_push  = w_push_ok;
                c_pdata = w_pt;
            end
            S_PUSHE: begin
                c_push  = w_push_ok;
                c_pdata = r_e;
            end
            S_OUT: begin
                c_pop = w_out_load;
            end
            default: begin
                c_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rdv   <= 1'b0;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_rdv <= r_valid[w_raddr];
            if (c_push && !c_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (c_pop && !c_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (c_push && r_state != S_CORN) begin
                r_m <= r_m + 1'b1;
            end
            if (r_ov && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_we) begin
                        r_valid[w_slot] <= 1'b1;
                    end
                    if (w_in_acc && w_op == bfcc_pkg::OP_START) begin
                        r_ref   <= (w_ref == 2'(bfcc_pkg::NUM_AXES)) ? 2'd0 : w_ref;
                        r_lc    <= '0;
                        r_state <= S_LD;
                    end
                end
                S_LD: begin
                    r_lc <= r_lc + 1'b1;
                    case (r_lc)
                        4'd1:    r_nrm <= w_ld;
                        4'd2:    r_fc  <= w_ld;
                        4'd3:    r_vn  <= w_ld;
                        4'd4:    r_hn  <= w_ld;
                        4'd5: begin
                            r_vh <= $signed(w_ld[w_vi]);
                            r_hh <= $signed(w_ld[w_hi]);
                        end
                        4'd6:    r_ih     <= w_ld;
                        4'd7:    r_ctr    <= w_ld;
                        4'd8:    r_inc[0] <= w_ld;
                        4'd9:    r_inc[1] <= w_ld;
                        4'd10: begin
                            r_inc[2] <= w_ld;
                            r_k      <= 2'd0;
                            r_state  <= S_DOT;
                        end
                        default: r_lc <= r_lc + 1'b1;
                    endcase
                end
                S_DOT: begin
                    r_ma <= r_inc[r_k]; r_mb <= r_nrm; r_ret <= S_DOTR;
                    r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_DOTR: begin
                    r_dot[r_k] <= sat(r_acc);
                    if (r_k == 2'd2) begin
                        r_state <= S_PICK;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DOT;
                    end
                end
                S_PICK: begin
                    r_b  <= w_pick;
                    r_bn <= w_pick_bn;
                    r_ma <= w_pick_bn;
                    r_mb <= {r_ih[w_pick], r_ih[w_pick], r_ih[w_pick]};
                    r_ret <= S_BC; r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_BC: begin
                    for (int j = 0; j < 3; j++) begin
                        r_bc[j] <= addq($signed(r_ctr[j]), $signed(r_res[j]));
                    end
                    r_ma <= r_inc[w_bv];
                    r_mb <= {r_ih[w_bv], r_ih[w_bv], r_ih[w_bv]};
                    r_ret <= S_U; r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_U: begin
                    r_u  <= r_res;
                    r_ma <= r_inc[w_bh];
                    r_mb <= {r_ih[w_bh], r_ih[w_bh], r_ih[w_bh]};
                    r_ret <= S_W; r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_W: begin
                    r_w     <= r_res;
                    r_k     <= 2'd0;
                    r_state <= S_CORN;
                end
                S_CORN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_n     <= 4'd4;
                        r_pass  <= 2'd0;
                        r_state <= S_PSET;
                    end
                end
                S_PSET: begin
                    r_pn <= w_pn;
                    r_ma <= w_pn; r_mb <= r_fc;
                    r_ret <= S_OFF; r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_OFF: begin
                    r_off <= sat(WW'(sat(r_acc)) + WW'(r_pass[1] ? r_hh : r_vh));
                    r_m   <= '0;
                    r_i   <= '0;
                    r_state <= (r_n == '0) ? S_PEND : S_PBEG;
                end
                S_PBEG: begin
                    r_s  <= w_head;
                    r_f  <= w_head;
                    r_ma <= r_pn; r_mb <= w_head;
                    r_ret <= S_DS; r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_DS: begin
                    r_ds    <= sat(WW'(sat(r_acc)) - WW'(r_off));
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_e  <= w_last_edge ? r_f : w_head;
                    r_ma <= r_pn; r_mb <= w_last_edge ? r_f : w_head;
                    r_ret <= S_DE; r_mk <= '0; r_acc <= '0; r_state <= S_MUL;
                end
                S_DE: begin
                    r_de    <= sat(WW'(sat(r_acc)) - WW'(r_off));
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= (w_in_s != w_in_e) ? S_DIV : S_NEXT;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_t     <= w_t;
                        r_k     <= 2'd0;
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    r_ip[r_k]   <= CW'(((CW+TB)'(w_ud) * (CW+TB)'(r_t)) >> TB);
                    r_dneg[r_k] <= w_dk[CW-1];
                    r_k         <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_state <= S_INT2;
                    end
                end
                S_INT2: begin
                    r_state <= w_in_e ? S_PUSHE : S_NEXT;
                end
                S_PUSHE: begin
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_s  <= r_e;
                    r_ds <= r_de;
                    if (w_last_edge) begin
                        r_n     <= r_m;
                        r_state <= S_PEND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EDGE;
                    end
                end
                S_PEND: begin
                    if (r_pass == 2'd3) begin
                        r_state <= S_OSTART;
                    end else begin
                        r_pass  <= r_pass + 1'b1;
                        r_state <= S_PSET;
                    end
                end
                S_OSTART: begin
                    r_oi    <= '0;
                    r_state <= (r_n == '0) ? S_OEMPTY : S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_ox     <= $signed(w_head[0]);
                        r_oy     <= $signed(w_head[1]);
                        r_oz     <= $signed(w_head[2]);
                        r_onum   <= r_oi;
                        r_olast  <= w_oi_last;
                        r_oempty <= 1'b0;
                        r_ov     <= 1'b1;
                        r_oi     <= r_oi + 1'b1;
                        if (w_oi_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OEMPTY: begin
                    if (w_out_load) begin
                        r_ox     <= '0;
                        r_oy     <= '0;
                        r_oz     <= '0;
                        r_onum   <= '0;
                        r_olast  <= 1'b1;
                        r_oempty <= 1'b1;
                        r_ov     <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_MUL: begin
                    if (r_mk != 2'd3) begin
                        r_prod <= qmul($signed(r_ma[r_mk]), $signed(r_mb[r_mk]));
                        r_pk   <= r_mk;
                        r_pv   <= 1'b1;
                        r_mk   <= r_mk + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_res[r_pk] <= r_prod;
                        r_acc       <= r_acc + WW'(r_prod);
                        if (r_pk == 2'd2) begin
                            r_state <= r_ret;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic w_oi_last;
    assign w_oi_last = ((4'(r_oi) + 4'd1) == r_n);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'd0, r_onum, 32'(r_oz), 32'(r_oy), 32'(r_ox)};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oempty;

endmodule

[rtl/bfcc_checker.sv]
// port level checks of the box face contact clipper, bound to the top level
module bfcc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [bfcc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [0:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [bfcc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                             o_m_axis_tlast,
    input logic [0:0]                       o_m_axis_tuser
);

    // an empty polygon is a single transaction
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("empty result without tlast");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("empty result with nonzero data");

    // vertex numbers count up within one polygon
    a_vertex_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
        !o_m_axis_tvalid ||
        o_m_axis_tdata[98:96] == $past(o_m_axis_tdata[98:96]) + 3'd1)
        else $error("vertex number out of sequence");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind box_face_contact_clipper_core bfcc_checker u_bfcc_checker (.*);
